// ===== rtl/tempo_breakpoint_interpolator_assert.svh =====
// ----------------------------------------------------------------------------
// tempo_breakpoint_interpolator_assert
// Assertion macros for the tempo breakpoint interpolator.
// ----------------------------------------------------------------------------
`ifndef TEMPO_BREAKPOINT_INTERPOLATOR_ASSERT_SVH
`define TEMPO_BREAKPOINT_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define TBI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TBI_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define TBI_ASSERT(label, prop, msg)
`define TBI_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== rtl/tbi_pkg.sv =====
// ----------------------------------------------------------------------------
// tbi_pkg
// Shared types and constants for the tempo breakpoint interpolator.
// ----------------------------------------------------------------------------
package tbi_pkg;
  localparam int unsigned MaxPoints = 64;
  localparam int unsigned AddrW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned TimeW = 31;
  localparam int unsigned TempoW = 20;
  localparam logic [TempoW-1:0] DefaultTempoRst = 20'd30720;

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpInsert = 2'd1,
    OpQuery = 2'd2,
    OpNone = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    AccIdle = 4'd0,
    AccRead = 4'd1,
    AccWrite = 4'd2,
    AccShift = 4'd3
  } acc_e;

  // controller -> datapath
  typedef struct packed {
    acc_e acc;           // memory action
    logic [AddrW-1:0] addr;
    logic capture_a;     // latch read data as lower point
    logic capture_b;     // latch read data as upper point
    logic div_start;
    logic cnt_clr;
    logic cnt_inc;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_lt;         // read time < clamped insert time
    logic rd_eq;         // read time == clamped insert time
    logic rd_le_q;       // read time <= query time (signed)
    logic rd_ge_q;       // read time >= query time
    logic div_done;
  } sts_t;
endpackage

// ===== rtl/tbi_ram.sv =====
// ----------------------------------------------------------------------------
// tbi_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tbi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic clk_i,
  input  logic we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/tbi_div.sv =====
// ----------------------------------------------------------------------------
// tbi_div
// Restoring divider, one quotient bit per cycle, signed dividend, positive divisor.
// ----------------------------------------------------------------------------
module tbi_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic signed [52:0] num_i,
  input  logic [31:0] den_i,
  output logic done_o,
  output logic signed [52:0] quo_o
);
  logic [51:0] rem_q, rem_d, quo_q, quo_d;
  logic [31:0] den_q;
  logic neg_q, busy_q, busy_d;
  logic [5:0] cnt_q, cnt_d;
  logic [32:0] trial;
  logic [51:0] mag;
  assign mag = num_i[52] ? 52'(-num_i) : num_i[51:0];
  assign trial = {rem_q[31:0], quo_q[51]} - {1'b0, den_q};
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; busy_d = busy_q; cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0; quo_d = mag; busy_d = 1'b1; cnt_d = 6'd0;
    end else if (busy_q) begin
      quo_d = {quo_q[50:0], ~trial[32]};
      rem_d = trial[32] ? {rem_q[50:0], quo_q[51]} : {19'd0, trial[32:0]};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd51) busy_d = 1'b0;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i; neg_q <= num_i[52];
    end
  end
  assign done_o = busy_q && (cnt_q == 6'd51);
  assign quo_o = neg_q ? -$signed({1'b0, quo_d}) : $signed({1'b0, quo_d});
endmodule

// ===== rtl/tbi_datapath.sv =====
// ----------------------------------------------------------------------------
// tbi_datapath
// Breakpoint memories, operand registers, interpolation arithmetic.
// ----------------------------------------------------------------------------
module tbi_datapath (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic signed [31:0] time_i,
  input  logic signed [20:0] tempo_i,
  input  logic [19:0] dflt_i,
  input  tbi_pkg::cmd_t cmd_i,
  output tbi_pkg::sts_t sts_o,
  output logic [tbi_pkg::CntW-1:0] count_o,
  output logic [19:0] rd_tempo_o,
  output logic [19:0] interp_o
);
  logic [30:0] ins_t_q, rd_t, wr_t;
  logic [19:0] ins_v_q, rd_v, wr_v, va_q, vb_q;
  logic [30:0] ta_q, tb_q;
  logic signed [31:0] qt_q;
  logic [tbi_pkg::CntW-1:0] cnt_q;
  logic we;
  logic signed [52:0] num, quo;
  logic [31:0] den;
  logic signed [20:0] dv;
  logic signed [32:0] dt;
  logic signed [52:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      qt_q <= time_i;
      ins_t_q <= time_i[31] ? '0 : time_i[30:0];
      ins_v_q <= (tempo_i[20] || tempo_i == '0) ? dflt_i : tempo_i[19:0];
    end
    if (cmd_i.capture_a) begin ta_q <= rd_t; va_q <= rd_v; end
    if (cmd_i.capture_b) begin tb_q <= rd_t; vb_q <= rd_v; end
    prod_q <= 53'(dv) * 53'(dt);
  end
  // shift writes the previously read entry one place up
  assign we = cmd_i.acc == tbi_pkg::AccWrite || cmd_i.acc == tbi_pkg::AccShift;
  assign wr_t = cmd_i.acc == tbi_pkg::AccShift ? rd_t : ins_t_q;
  assign wr_v = cmd_i.acc == tbi_pkg::AccShift ? rd_v : ins_v_q;

  tbi_ram #(.Width(tbi_pkg::TimeW), .Depth(tbi_pkg::MaxPoints)) u_times (
    .clk_i, .we_i(we), .addr_i(cmd_i.addr), .wdata_i(wr_t), .rdata_o(rd_t));
  tbi_ram #(.Width(tbi_pkg::TempoW), .Depth(tbi_pkg::MaxPoints)) u_tempos (
    .clk_i, .we_i(we), .addr_i(cmd_i.addr), .wdata_i(wr_v), .rdata_o(rd_v));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (cmd_i.cnt_clr) cnt_q <= '0;
    else if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
  end

  assign dv = $signed({1'b0, vb_q}) - $signed({1'b0, va_q});
  assign dt = $signed({qt_q[31], qt_q}) - $signed({2'b0, ta_q});
  assign num = prod_q;
  assign den = 32'({1'b0, tb_q} - {1'b0, ta_q});
  tbi_div u_div (.clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(num),
    .den_i(den), .done_o(sts_o.div_done), .quo_o(quo));

  assign sts_o.rd_lt = rd_t < ins_t_q;
  assign sts_o.rd_eq = rd_t == ins_t_q;
  assign sts_o.rd_le_q = $signed({1'b0, rd_t}) <= qt_q;
  assign sts_o.rd_ge_q = $signed({1'b0, rd_t}) >= qt_q;
  assign count_o = cnt_q;
  assign rd_tempo_o = rd_v;
  assign interp_o = 20'(va_q + quo[19:0]);
endmodule

// ===== rtl/tbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbi_ctrl
// Sequencer for clear, insert and query.
// ----------------------------------------------------------------------------
`include "tempo_breakpoint_interpolator_assert.svh"
module tbi_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] opcode_i,
  output logic out_valid,
  input  logic out_stall,
  output logic [19:0] tempo_out_o,
  output logic status_o,
  output logic [6:0] point_count_o,
  output logic load_o,
  input  logic [19:0] dflt_i,
  input  logic [19:0] rd_tempo_i,
  input  logic [19:0] interp_i,
  input  logic [tbi_pkg::CntW-1:0] count_i,
  input  tbi_pkg::sts_t sts_i,
  output tbi_pkg::cmd_t cmd_o
);
  localparam int unsigned AW = tbi_pkg::AddrW;
  localparam int unsigned CW = tbi_pkg::CntW;
  typedef enum logic [10:0] {
    SIdle = 11'b00000000001, SScan = 11'b00000000010, SScanChk = 11'b00000000100,
    SShRd = 11'b00000001000, SShWr = 11'b00000010000, SPut = 11'b00000100000,
    SQRd = 11'b00001000000, SQChk = 11'b00010000000, SDiv = 11'b00100000000,
    SFin = 11'b01000000000, SStart = 11'b10000000000
  } state_e;
  state_e st_q, st_d;
  logic [CW-1:0] i_q, i_d, p_q, p_d;
  logic first_q, first_d;
  logic ov_q, ov_d, stat_q, stat_d;
  logic [19:0] res_q, res_d;
  logic inc_d;
  logic [CW-1:0] last;
  assign last = count_i - 1'b1;
  assign load_o = in_valid && !in_stall;
  assign in_stall = st_q != SIdle || ov_q;

  always_comb begin
    st_d = st_q; i_d = i_q; p_d = p_q; first_d = first_q; ov_d = ov_q;
    stat_d = stat_q; res_d = res_q; inc_d = 1'b0;
    cmd_o = '0; cmd_o.acc = tbi_pkg::AccIdle; cmd_o.addr = AW'(i_q);
    if (out_valid && !out_stall) ov_d = 1'b0;
    unique case (st_q)
      SIdle: if (load_o) begin
        res_d = '0; stat_d = 1'b0; i_d = '0;
        unique case (tbi_pkg::op_e'(opcode_i))
          tbi_pkg::OpClear: begin cmd_o.cnt_clr = 1'b1; ov_d = 1'b1; end
          tbi_pkg::OpInsert: st_d = count_i == '0 ? SPut : SScan;
          tbi_pkg::OpQuery: begin
            if (count_i == '0) begin res_d = dflt_i; ov_d = 1'b1; end
            else begin st_d = SQRd; first_d = 1'b1; end
          end
          default: ov_d = 1'b1;
        endcase
        p_d = '0;
      end
      SScan: begin cmd_o.acc = tbi_pkg::AccRead; st_d = SScanChk; end
      SScanChk: begin
        if (sts_i.rd_lt && i_q + 1'b1 < count_i) begin
          i_d = i_q + 1'b1; st_d = SScan;
        end else if (sts_i.rd_eq) begin
          p_d = i_q; st_d = SPut;
        end else if (count_i >= CW'(tbi_pkg::MaxPoints)) begin
          stat_d = 1'b1; ov_d = 1'b1; st_d = SIdle;
        end else begin
          p_d = sts_i.rd_lt ? count_i : i_q;
          i_d = count_i; inc_d = 1'b1;
          st_d = sts_i.rd_lt ? SPut : SShRd;
        end
      end
      SShRd: begin
        cmd_o.acc = tbi_pkg::AccRead; cmd_o.addr = AW'(i_q - 1'b1); st_d = SShWr;
      end
      SShWr: begin
        cmd_o.acc = tbi_pkg::AccShift;
        i_d = i_q - 1'b1;
        st_d = (i_q - 1'b1 == p_q) ? SPut : SShRd;
      end
      SPut: begin
        cmd_o.acc = tbi_pkg::AccWrite; cmd_o.addr = AW'(p_q);
        if (count_i == '0) inc_d = 1'b1;
        ov_d = 1'b1; st_d = SIdle;
      end
      SQRd: begin cmd_o.acc = tbi_pkg::AccRead; st_d = SQChk; end
      SQChk: begin
        cmd_o.capture_b = 1'b1;
        cmd_o.capture_a = first_q || sts_i.rd_le_q;
        first_d = 1'b0;
        if (first_q && sts_i.rd_ge_q) begin
          res_d = rd_tempo_i; ov_d = 1'b1; st_d = SIdle;
        end else if (i_q == last) begin
          if (sts_i.rd_le_q) begin res_d = rd_tempo_i; ov_d = 1'b1; st_d = SIdle; end
          else st_d = SFin;
        end else if (sts_i.rd_le_q || first_q) begin
          i_d = i_q + 1'b1; st_d = SQRd;
        end else st_d = SFin;
      end
      SFin: st_d = SStart;
      SStart: begin cmd_o.div_start = 1'b1; st_d = SDiv; end
      SDiv: if (sts_i.div_done) begin st_d = SIdle; ov_d = 1'b1; end
      default: st_d = SIdle;
    endcase
    cmd_o.cnt_inc = inc_d;
  end
  // SFin waits for the product register to load before the divider starts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; ov_q <= 1'b0; i_q <= '0; p_q <= '0; first_q <= 1'b0;
    end else begin
      st_q <= st_d; ov_q <= ov_d; i_q <= i_d; p_q <= p_d; first_q <= first_d;
    end
  end
  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    res_q <= (st_q == SDiv && sts_i.div_done) ? interp_i : res_d;
  end
  assign out_valid = ov_q;
  assign tempo_out_o = res_q;
  assign status_o = stat_q;
  assign point_count_o = 7'(count_i);

  `TBI_ASSERT(a_onehot, $onehot(st_q), "state not one-hot")
  `TBI_ASSERT_NEXT(a_busy, st_q != SIdle, in_stall, "input taken while busy")
  `TBI_ASSERT_NEXT(a_full, 1'b1, count_i <= CW'(tbi_pkg::MaxPoints), "count overflow")
  `TBI_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(tempo_out_o), "result lost")
endmodule

// ===== rtl/tempo_breakpoint_interpolator.sv =====
// ----------------------------------------------------------------------------
// tempo_breakpoint_interpolator
// Sorted tempo breakpoint table with piecewise linear interpolation.
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_stall   | opcode_i, time_ms_i, tempo_in_i
// out     | out | out_valid/out_stall | tempo_out_o, status_o, point_count_o
// cfg     | in  | cfg_valid/cfg_ready | cfg_data_i (default_tempo)
// Insert scans the table entry by entry, then shifts each later entry up one
// place, as the single-port table RAMs take one read or write at a time.
// Query scans entry by entry, then runs the bit-serial divider.
// One word in flight; the input stalls until the result word is taken.
// Reset empties the table; entry contents are not cleared.
module tempo_breakpoint_interpolator (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] opcode_i,
  input  logic signed [31:0] time_ms_i,
  input  logic signed [20:0] tempo_in_i,
  output logic out_valid,
  input  logic out_stall,
  output logic [19:0] tempo_out_o,
  output logic status_o,
  output logic [6:0] point_count_o,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [19:0] cfg_data_i
);
  logic [19:0] dflt_q;
  logic load;
  logic [19:0] rd_tempo, interp;
  logic [tbi_pkg::CntW-1:0] count;
  tbi_pkg::cmd_t cmd;
  tbi_pkg::sts_t sts;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dflt_q <= tbi_pkg::DefaultTempoRst;
    else if (cfg_valid && cfg_ready) dflt_q <= cfg_data_i;
  end

  tbi_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid, .in_stall, .opcode_i, .out_valid,
    .out_stall, .tempo_out_o, .status_o, .point_count_o, .load_o(load),
    .dflt_i(dflt_q), .rd_tempo_i(rd_tempo), .interp_i(interp), .count_i(count),
    .sts_i(sts), .cmd_o(cmd));
  tbi_datapath u_dp (.clk_i, .rst_ni, .load_i(load), .time_i(time_ms_i),
    .tempo_i(tempo_in_i), .dflt_i(dflt_q), .cmd_i(cmd), .sts_o(sts),
    .count_o(count), .rd_tempo_o(rd_tempo), .interp_o(interp));
endmodule
